>>> hdl/wlss_pkg.sv
package wlss_pkg;

    localparam int SLOT_BYTES_DEF  = 30;
    localparam int STORE_BYTES_DEF = 512;
    localparam int SLOT_IDX_W      = 5;
    localparam logic [7:0] ERASED  = 8'hFF;

    typedef logic [3:0] step_t;

    localparam step_t S_IDLE    = 4'd0;
    localparam step_t S_DISP    = 4'd1;
    localparam step_t S_RD_CHK  = 4'd2;
    localparam step_t S_RD_ADDR = 4'd3;
    localparam step_t S_RD_EMIT = 4'd4;
    localparam step_t S_RD_NEXT = 4'd5;
    localparam step_t S_RD_LOOP = 4'd6;
    localparam step_t S_NF      = 4'd7;
    localparam step_t S_NF_END  = 4'd8;
    localparam step_t S_CP_RD   = 4'd9;
    localparam step_t S_CP_WR   = 4'd10;
    localparam step_t S_CP_NEXT = 4'd11;
    localparam step_t S_CP_ACK  = 4'd12;
    localparam step_t S_CP_END  = 4'd13;

    typedef enum logic [1:0] {
        E_NONE,
        E_READ,
        E_NOT_FOUND,
        E_ACK
    } emit_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_IDLE_HOLD,
        C_OP_STORE,
        C_EMPTY,
        C_CNT_LAST,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  take_in;
        emit_t emit;
        logic  clr_cnt;
        logic  inc_cnt;
        logic  rd_store;
        logic  rd_buf;
        logic  wr_store;
        logic  clr_any;
        logic  commit;
    } ctrl_t;

    typedef struct packed {
        logic idle_hold;
        logic op_store;
        logic empty;
        logic cnt_last;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
    } uword_t;

    function automatic uword_t ucode(step_t s);
        uword_t w;
        w.ctrl.take_in  = 1'b0;
        w.ctrl.emit     = E_NONE;
        w.ctrl.clr_cnt  = 1'b0;
        w.ctrl.inc_cnt  = 1'b0;
        w.ctrl.rd_store = 1'b0;
        w.ctrl.rd_buf   = 1'b0;
        w.ctrl.wr_store = 1'b0;
        w.ctrl.clr_any  = 1'b0;
        w.ctrl.commit   = 1'b0;
        w.cond          = C_NEVER;
        w.target        = S_IDLE;
        case (s)
            S_IDLE:
            begin
                w.ctrl.take_in = 1'b1;
                w.cond         = C_IDLE_HOLD;
                w.target       = S_IDLE;
            end
            S_DISP:
            begin
                w.ctrl.clr_cnt = 1'b1;
                w.ctrl.clr_any = 1'b1;
                w.cond         = C_OP_STORE;
                w.target       = S_CP_RD;
            end
            S_RD_CHK:
            begin
                w.cond   = C_EMPTY;
                w.target = S_NF;
            end
            S_RD_ADDR:
            begin
                w.ctrl.rd_store = 1'b1;
            end
            S_RD_EMIT:
            begin
                w.ctrl.emit = E_READ;
                w.cond      = C_OUT_BUSY;
                w.target    = S_RD_EMIT;
            end
            S_RD_NEXT:
            begin
                w.ctrl.inc_cnt = 1'b1;
                w.cond         = C_CNT_LAST;
                w.target       = S_IDLE;
            end
            S_RD_LOOP:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_RD_ADDR;
            end
            S_NF:
            begin
                w.ctrl.emit = E_NOT_FOUND;
                w.cond      = C_OUT_BUSY;
                w.target    = S_NF;
            end
            S_NF_END:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
            S_CP_RD:
            begin
                w.ctrl.rd_buf = 1'b1;
            end
            S_CP_WR:
            begin
                w.ctrl.wr_store = 1'b1;
                w.cond          = C_CNT_LAST;
                w.target        = S_CP_ACK;
            end
            S_CP_NEXT:
            begin
                w.ctrl.inc_cnt = 1'b1;
                w.cond         = C_ALWAYS;
                w.target       = S_CP_RD;
            end
            S_CP_ACK:
            begin
                w.ctrl.emit = E_ACK;
                w.cond      = C_OUT_BUSY;
                w.target    = S_CP_ACK;
            end
            S_CP_END:
            begin
                w.ctrl.commit = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = S_IDLE;
            end
            default:
            begin
                w.cond   = C_ALWAYS;
                w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> hdl/wlss_if.sv
interface wlss_req_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] record_byte;

    modport source (output valid, operation, record_byte, input ready);
    modport sink (input valid, operation, record_byte, output ready);
endinterface

interface wlss_rsp_if;
    logic       valid;
    logic       ready;
    logic       reply_kind;
    logic       found;
    logic [4:0] slot_index;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, reply_kind, found, slot_index, data_byte, last,
                    input ready);
    modport sink (input valid, reply_kind, found, slot_index, data_byte, last,
                  output ready);
endinterface

>>> hdl/wlss_seq.sv
module wlss_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  wlss_pkg::stat_t stat,
    output wlss_pkg::ctrl_t ctrl
);

    wlss_pkg::step_t  pc_reg;
    wlss_pkg::step_t  pc_next;
    wlss_pkg::uword_t uword;
    logic             cond_true;

    assign uword = wlss_pkg::ucode(pc_reg);
    assign ctrl  = uword.ctrl;

    always_comb
    begin
        case (uword.cond)
            wlss_pkg::C_NEVER:     cond_true = 1'b0;
            wlss_pkg::C_ALWAYS:    cond_true = 1'b1;
            wlss_pkg::C_IDLE_HOLD: cond_true = stat.idle_hold;
            wlss_pkg::C_OP_STORE:  cond_true = stat.op_store;
            wlss_pkg::C_EMPTY:     cond_true = stat.empty;
            wlss_pkg::C_CNT_LAST:  cond_true = stat.cnt_last;
            wlss_pkg::C_OUT_BUSY:  cond_true = stat.out_busy;
            default:               cond_true = 1'b1;
        endcase
        pc_next = cond_true ? uword.target : pc_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= wlss_pkg::S_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/wear_leveled_slot_store.sv
// store byte: accepted back to back; the final byte starts the copy of the record into the next slot
// read: every byte of the used slot is sent, or one not-found word for an empty store
// a reply held off by the receiver stalls the microcode for as long as it waits
// rate is set by the microcode loop over one slot, one byte per pass through the store port
// reset leaves the store logically erased through a used-slot flag, so no clearing pass runs
// results wait in an output register while the next word is taken
module wear_leveled_slot_store #(
    parameter int SLOT_BYTES  = wlss_pkg::SLOT_BYTES_DEF,
    parameter int STORE_BYTES = wlss_pkg::STORE_BYTES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    wlss_req_if.sink   req,
    wlss_rsp_if.source rsp
);

    localparam int SLOTS     = STORE_BYTES / SLOT_BYTES;
    localparam int MEM_DEPTH = SLOTS * SLOT_BYTES;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int BUF_W     = (SLOT_BYTES > 1) ? $clog2(SLOT_BYTES) : 1;
    localparam int CNT_W     = $clog2(SLOT_BYTES + 1);

    wlss_pkg::ctrl_t ctrl;
    wlss_pkg::stat_t stat;

    logic [7:0]        store_mem [MEM_DEPTH];
    logic [7:0]        buf_mem [SLOT_BYTES];
    logic [7:0]        store_q_reg;
    logic [7:0]        buf_q_reg;

    logic [CNT_W-1:0]  incoming_count_reg;
    logic [BUF_W-1:0]  cnt_reg;
    logic              op_reg;
    logic              any_reg;
    logic              used_valid_reg;
    logic [SLOT_W-1:0] used_slot_reg;
    logic [ADDR_W-1:0] used_base_reg;

    logic              rsp_valid_reg;
    logic              rsp_kind_reg;
    logic              rsp_found_reg;
    logic [4:0]        rsp_slot_reg;
    logic [7:0]        rsp_data_reg;
    logic              rsp_last_reg;

    logic              req_fire;
    logic              final_byte;
    logic              cnt_last;
    logic              out_busy;
    logic              emit_fire;
    logic [SLOT_W-1:0] tgt_slot;
    logic [ADDR_W-1:0] tgt_base;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       used_slot_w;
    logic [31:0]       tgt_slot_w;

    wlss_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    assign req.ready  = ctrl.take_in;
    assign req_fire   = req.valid && req.ready;
    assign final_byte = (incoming_count_reg == CNT_W'(SLOT_BYTES - 1));
    assign cnt_last   = (cnt_reg == BUF_W'(SLOT_BYTES - 1));
    assign out_busy   = rsp_valid_reg && !rsp.ready;
    assign emit_fire  = (ctrl.emit != wlss_pkg::E_NONE) && !out_busy;

    assign stat.idle_hold = !req.valid || (req.operation && !final_byte);
    assign stat.op_store  = op_reg;
    assign stat.empty     = !used_valid_reg;
    assign stat.cnt_last  = cnt_last;
    assign stat.out_busy  = out_busy;

    // slot after the used one, wrapping; slot 0 when nothing is stored
    always_comb
    begin
        if (!used_valid_reg || used_slot_reg == SLOT_W'(SLOTS - 1))
        begin
            tgt_slot = '0;
            tgt_base = '0;
        end
        else
        begin
            tgt_slot = used_slot_reg + SLOT_W'(1);
            tgt_base = used_base_reg + ADDR_W'(SLOT_BYTES);
        end
    end

    assign rd_addr     = used_base_reg + ADDR_W'(cnt_reg);
    assign wr_addr     = tgt_base + ADDR_W'(cnt_reg);
    assign used_slot_w = 32'(used_slot_reg);
    assign tgt_slot_w  = 32'(tgt_slot);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_store)
        begin
            store_mem[wr_addr] <= buf_q_reg;
        end
        if (ctrl.rd_store)
        begin
            store_q_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire && req.operation)
        begin
            buf_mem[incoming_count_reg[BUF_W-1:0]] <= req.record_byte;
        end
        if (ctrl.rd_buf)
        begin
            buf_q_reg <= buf_mem[cnt_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incoming_count_reg <= '0;
            cnt_reg            <= '0;
            op_reg             <= 1'b0;
            any_reg            <= 1'b0;
            used_valid_reg     <= 1'b0;
            used_slot_reg      <= '0;
            used_base_reg      <= '0;
            rsp_valid_reg      <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                op_reg <= req.operation;
                if (!req.operation || final_byte)
                begin
                    incoming_count_reg <= '0;
                end
                else
                begin
                    incoming_count_reg <= incoming_count_reg + CNT_W'(1);
                end
            end
            if (ctrl.clr_cnt)
            begin
                cnt_reg <= '0;
            end
            else if (ctrl.inc_cnt)
            begin
                cnt_reg <= cnt_reg + BUF_W'(1);
            end
            if (ctrl.clr_any)
            begin
                any_reg <= 1'b0;
            end
            else if (ctrl.wr_store && buf_q_reg != wlss_pkg::ERASED)
            begin
                any_reg <= 1'b1;
            end
            // old slot counts as erased from here on
            if (ctrl.commit)
            begin
                used_valid_reg <= any_reg;
                used_slot_reg  <= tgt_slot;
                used_base_reg  <= tgt_base;
            end
            if (emit_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            case (ctrl.emit)
                wlss_pkg::E_READ:
                begin
                    rsp_kind_reg  <= 1'b0;
                    rsp_found_reg <= 1'b1;
                    rsp_slot_reg  <= used_slot_w[wlss_pkg::SLOT_IDX_W-1:0];
                    rsp_data_reg  <= store_q_reg;
                    rsp_last_reg  <= cnt_last;
                end
                wlss_pkg::E_ACK:
                begin
                    rsp_kind_reg  <= 1'b1;
                    rsp_found_reg <= 1'b1;
                    rsp_slot_reg  <= tgt_slot_w[wlss_pkg::SLOT_IDX_W-1:0];
                    rsp_data_reg  <= '0;
                    rsp_last_reg  <= 1'b1;
                end
                default:
                begin
                    rsp_kind_reg  <= 1'b0;
                    rsp_found_reg <= 1'b0;
                    rsp_slot_reg  <= '0;
                    rsp_data_reg  <= '0;
                    rsp_last_reg  <= 1'b1;
                end
            endcase
        end
    end

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.reply_kind = rsp_kind_reg;
    assign rsp.found      = rsp_found_reg;
    assign rsp.slot_index = rsp_slot_reg;
    assign rsp.data_byte  = rsp_data_reg;
    assign rsp.last       = rsp_last_reg;

    a_ack_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.reply_kind |-> rsp.found && rsp.last && rsp.data_byte == 8'd0)
        else $error("acknowledgement word malformed");

    a_not_found_form: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.found |-> rsp.last && rsp.slot_index == 5'd0 && !rsp.reply_kind)
        else $error("not-found word malformed");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        incoming_count_reg < CNT_W'(SLOT_BYTES))
        else $error("incoming byte count out of range");

    a_final_starts_copy: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.operation && final_byte |=> !req.ready && incoming_count_reg == '0)
        else $error("final record byte did not start the slot write");

endmodule
